FILE: src/spring_pair_velocity_delta_defines.svh
// ----------------------------------------------------------------------------
// spring pair velocity delta assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef SPRING_PAIR_VELOCITY_DELTA_DEFINES_SVH
`define SPRING_PAIR_VELOCITY_DELTA_DEFINES_SVH

// same-cycle implication, off during reset
`define SPV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SPV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/spv_pkg.sv
// ----------------------------------------------------------------------------
// spv_pkg
// widths, constants and stage records of the spring pair velocity delta block
// ----------------------------------------------------------------------------
package spv_pkg;

  // field widths
  localparam int POS_W   = 32;
  localparam int UQ_W    = 31;
  localparam int DIFF_W  = 33;
  localparam int RAD_W   = 66;
  localparam int ROOT_W  = 33;
  localparam int SREM_W  = 35;
  localparam int DREM_W  = 33;
  localparam int DVD_W   = 47;
  localparam int Q_W     = 47;
  localparam int U_W     = 17;
  localparam int STR_W   = 35;
  localparam int SMAG_W  = 33;
  localparam int FORCE_W = 48;
  localparam int HALF_W  = 24;
  localparam int R_W     = 56;
  localparam int FRAC_W  = 16;

  // fixed values
  localparam logic [UQ_W-1:0]   TS_RESET   = 31'd1092;
  localparam logic [ROOT_W-1:0] NEAR_LIMIT = 33'd6554;
  localparam logic [U_W-1:0]    U_ONE      = 17'd65536;
  localparam logic [R_W-1:0]    CAP_POS    = 56'h7FFF_FFFF;
  localparam logic [R_W-1:0]    CAP_NEG    = 56'h8000_0000;

  // pipeline layout
  localparam int SQRT_STEPS = 33;
  localparam int QDIV_STEPS = 47;
  localparam int UDIV_STEPS = 17;
  localparam int IT_STAGES  = SQRT_STEPS + UDIV_STEPS;
  localparam int NUM_STAGES = IT_STAGES + 10;

  // per-item data carried along the iteration stages
  typedef struct packed {
    logic [DIFF_W-1:0] ax;
    logic [DIFF_W-1:0] ay;
    logic              sx;
    logic              sy;
    logic              mode;
    logic [DIFF_W-1:0] rgsum;
    logic [UQ_W-1:0]   gain;
    logic [UQ_W-1:0]   m1;
    logic [UQ_W-1:0]   m2;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [RAD_W-1:0]  rad;
    logic [SREM_W-1:0] srem;
    logic [ROOT_W-1:0] root;
    logic [DVD_W-1:0]  dvd;
    logic [DREM_W-1:0] d1rem;
    logic [DREM_W-1:0] d2rem;
    logic [Q_W-1:0]    q1;
    logic [Q_W-1:0]    q2;
    logic [DREM_W-1:0] uxrem;
    logic [DREM_W-1:0] uyrem;
    logic [U_W-1:0]    ux;
    logic [U_W-1:0]    uy;
  } it_t;

endpackage

FILE: src/spv_if.sv
// ----------------------------------------------------------------------------
// spv_in_if / spv_out_if
// valid/ready channels for body pairs and velocity changes
// ----------------------------------------------------------------------------
interface spv_in_if import spv_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [UQ_W-1:0]        rest_gap;
  logic [UQ_W-1:0]        force_gain;
  logic signed [POS_W-1:0] first_x;
  logic signed [POS_W-1:0] first_y;
  logic [UQ_W-1:0]        first_radius;
  logic [UQ_W-1:0]        first_mass;
  logic signed [POS_W-1:0] second_x;
  logic signed [POS_W-1:0] second_y;
  logic [UQ_W-1:0]        second_radius;
  logic [UQ_W-1:0]        second_mass;

  modport source (output valid, mode, rest_gap, force_gain, first_x, first_y,
                  first_radius, first_mass, second_x, second_y, second_radius,
                  second_mass, input ready);
  modport sink (input valid, mode, rest_gap, force_gain, first_x, first_y,
                first_radius, first_mass, second_x, second_y, second_radius,
                second_mass, output ready);
endinterface

interface spv_out_if import spv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] first_dv_x;
  logic signed [POS_W-1:0] first_dv_y;
  logic signed [POS_W-1:0] second_dv_x;
  logic signed [POS_W-1:0] second_dv_y;

  modport source (output valid, first_dv_x, first_dv_y, second_dv_x, second_dv_y,
                  input ready);
  modport sink (input valid, first_dv_x, first_dv_y, second_dv_x, second_dv_y,
                output ready);
endinterface

FILE: src/spring_pair_velocity_delta.sv
// ----------------------------------------------------------------------------
// spring_pair_velocity_delta
// hookean spring between two round bodies, velocity changes in Q16.16
// ----------------------------------------------------------------------------
// Fully pipelined: one body pair is taken every clock while no result waits
// at the output. Most of the stages come from the 33-step square root for
// the centre distance followed by the 17-step division for the unit
// direction; the 47-step dt/mass divisions run beside them in the same
// stages. When a result waits at the output the whole pipeline holds, so
// nothing is dropped or repeated. time_step is sampled when an item enters
// and resets to 1092 (about 1/60).
module spring_pair_velocity_delta import spv_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  spv_in_if.sink          in_item,
  spv_out_if.source       out_item,
  input  logic            cfg_we,
  input  logic [UQ_W-1:0] cfg_wdata
);

  logic [UQ_W-1:0]       time_step_r;
  logic                  en;
  logic [NUM_STAGES-1:0] vld_r;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= TS_RESET;
    end else if (cfg_we) begin
      time_step_r <= cfg_wdata;
    end
  end

  // global advance, valid bits travel with the data
  assign en             = !vld_r[NUM_STAGES-1] || out_item.ready;
  assign in_item.ready  = en;
  assign out_item.valid = vld_r[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NUM_STAGES-2:0], in_item.valid};
    end
  end

  // stage a: offsets, magnitudes, summed radii and gap
  logic [DIFF_W-1:0] dx, dy;
  side_t             a_side_nxt, a_side_r;
  logic [UQ_W-1:0]   a_ts_r;

  assign dx = {in_item.second_x[POS_W-1], in_item.second_x}
            - {in_item.first_x[POS_W-1], in_item.first_x};
  assign dy = {in_item.second_y[POS_W-1], in_item.second_y}
            - {in_item.first_y[POS_W-1], in_item.first_y};

  always_comb begin
    a_side_nxt.ax    = dx[DIFF_W-1] ? (DIFF_W'(0) - dx) : dx;
    a_side_nxt.ay    = dy[DIFF_W-1] ? (DIFF_W'(0) - dy) : dy;
    a_side_nxt.sx    = dx[DIFF_W-1];
    a_side_nxt.sy    = dy[DIFF_W-1];
    a_side_nxt.mode  = in_item.mode;
    a_side_nxt.rgsum = DIFF_W'(in_item.first_radius) + DIFF_W'(in_item.second_radius)
                     + DIFF_W'(in_item.rest_gap);
    a_side_nxt.gain  = in_item.force_gain;
    a_side_nxt.m1    = (in_item.first_mass == '0) ? UQ_W'(1) : in_item.first_mass;
    a_side_nxt.m2    = (in_item.second_mass == '0) ? UQ_W'(1) : in_item.second_mass;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r <= a_side_nxt;
      a_ts_r   <= time_step_r;
    end
  end

  // stage b: squares
  side_t            b_side_r;
  logic [UQ_W-1:0]  b_ts_r;
  logic [RAD_W-1:0] b_sqx_r, b_sqy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      b_side_r <= a_side_r;
      b_ts_r   <= a_ts_r;
      b_sqx_r  <= a_side_r.ax * a_side_r.ax;
      b_sqy_r  <= a_side_r.ay * a_side_r.ay;
    end
  end

  // iteration stages: root, then direction quotients; dt/mass alongside
  it_t it_r [0:IT_STAGES];
  it_t it0_nxt;

  always_comb begin
    it0_nxt       = '0;
    it0_nxt.side  = b_side_r;
    it0_nxt.rad   = b_sqx_r + b_sqy_r;
    it0_nxt.dvd   = {b_ts_r, {FRAC_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it_r[0] <= it0_nxt;
    end
  end

  for (genvar k = 0; k < IT_STAGES; k++) begin : g_it
    it_t               nxt;
    logic [RAD_W-1:0]  rad_o;
    logic [SREM_W-1:0] srem_o;
    logic [ROOT_W-1:0] root_o;
    logic [DREM_W-1:0] uxrem_o, uyrem_o;
    logic [U_W-1:0]    ux_o, uy_o;
    logic [DVD_W-1:0]  dvd_o;
    logic [DREM_W-1:0] d1rem_o, d2rem_o;
    logic [Q_W-1:0]    q1_o, q2_o;

    if (k < SQRT_STEPS) begin : g_root
      spv_root_step u_root (
        .rem_i  (it_r[k].srem),
        .root_i (it_r[k].root),
        .pair_i (it_r[k].rad[RAD_W-1 -: 2]),
        .rem_o  (srem_o),
        .root_o (root_o)
      );
      assign rad_o   = it_r[k].rad << 2;
      assign uxrem_o = it_r[k].uxrem;
      assign uyrem_o = it_r[k].uyrem;
      assign ux_o    = it_r[k].ux;
      assign uy_o    = it_r[k].uy;
    end else begin : g_dir
      logic [DREM_W-1:0] xrem_i, yrem_i;
      logic              xbit_i, ybit_i, xq, yq;

      // first step starts from |d|>>1, the low dividend bits follow
      assign xrem_i = (k == SQRT_STEPS) ? {1'b0, it_r[k].side.ax[DIFF_W-1:1]}
                                        : it_r[k].uxrem;
      assign yrem_i = (k == SQRT_STEPS) ? {1'b0, it_r[k].side.ay[DIFF_W-1:1]}
                                        : it_r[k].uyrem;
      assign xbit_i = (k == SQRT_STEPS) ? it_r[k].side.ax[0] : 1'b0;
      assign ybit_i = (k == SQRT_STEPS) ? it_r[k].side.ay[0] : 1'b0;

      spv_div_step u_ux (
        .rem_i (xrem_i),
        .bit_i (xbit_i),
        .dvs_i (it_r[k].root),
        .rem_o (uxrem_o),
        .q_o   (xq)
      );
      spv_div_step u_uy (
        .rem_i (yrem_i),
        .bit_i (ybit_i),
        .dvs_i (it_r[k].root),
        .rem_o (uyrem_o),
        .q_o   (yq)
      );
      assign ux_o   = {it_r[k].ux[U_W-2:0], xq};
      assign uy_o   = {it_r[k].uy[U_W-2:0], yq};
      assign rad_o  = it_r[k].rad;
      assign srem_o = it_r[k].srem;
      assign root_o = it_r[k].root;
    end

    if (k < QDIV_STEPS) begin : g_q
      logic b1, b2;

      spv_div_step u_q1 (
        .rem_i (it_r[k].d1rem),
        .bit_i (it_r[k].dvd[DVD_W-1]),
        .dvs_i ({2'b00, it_r[k].side.m1}),
        .rem_o (d1rem_o),
        .q_o   (b1)
      );
      spv_div_step u_q2 (
        .rem_i (it_r[k].d2rem),
        .bit_i (it_r[k].dvd[DVD_W-1]),
        .dvs_i ({2'b00, it_r[k].side.m2}),
        .rem_o (d2rem_o),
        .q_o   (b2)
      );
      assign dvd_o = it_r[k].dvd << 1;
      assign q1_o  = {it_r[k].q1[Q_W-2:0], b1};
      assign q2_o  = {it_r[k].q2[Q_W-2:0], b2};
    end else begin : g_qhold
      assign dvd_o   = it_r[k].dvd;
      assign d1rem_o = it_r[k].d1rem;
      assign d2rem_o = it_r[k].d2rem;
      assign q1_o    = it_r[k].q1;
      assign q2_o    = it_r[k].q2;
    end

    always_comb begin
      nxt       = it_r[k];
      nxt.rad   = rad_o;
      nxt.srem  = srem_o;
      nxt.root  = root_o;
      nxt.uxrem = uxrem_o;
      nxt.uyrem = uyrem_o;
      nxt.ux    = ux_o;
      nxt.uy    = uy_o;
      nxt.dvd   = dvd_o;
      nxt.d1rem = d1rem_o;
      nxt.d2rem = d2rem_o;
      nxt.q1    = q1_o;
      nxt.q2    = q2_o;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it_r[k+1] <= nxt;
      end
    end
  end

  // stage e: stretch, repel clamp, direction and signs
  it_t               it_end;
  logic [STR_W-1:0]  st, st_neg;
  logic              sneg, near, clamp;
  logic [SMAG_W-1:0] e_smag_r;
  logic [UQ_W-1:0]   e_gain_r;
  logic [U_W-1:0]    e_ux_r, e_uy_r;
  logic              e_negx_r, e_negy_r;
  logic [Q_W-1:0]    e_q1_r, e_q2_r;

  assign it_end = it_r[IT_STAGES];
  assign st     = {2'b00, it_end.root} - {2'b00, it_end.side.rgsum};
  assign st_neg = STR_W'(0) - st;
  assign sneg   = st[STR_W-1];
  assign near   = it_end.root < NEAR_LIMIT;
  assign clamp  = it_end.side.mode && !sneg;

  always_ff @(posedge clk) begin
    if (en) begin
      e_smag_r <= sneg ? st_neg[SMAG_W-1:0] : (clamp ? '0 : st[SMAG_W-1:0]);
      e_gain_r <= it_end.side.gain;
      e_ux_r   <= near ? U_ONE : it_end.ux;
      e_uy_r   <= near ? '0 : it_end.uy;
      e_negx_r <= near ? sneg : (sneg ^ it_end.side.sx);
      e_negy_r <= near ? sneg : (sneg ^ it_end.side.sy);
      e_q1_r   <= it_end.q1;
      e_q2_r   <= it_end.q2;
    end
  end

  // stage f: gain times stretch, two partial products
  logic [FORCE_W-1:0] f_pl_r;
  logic [FORCE_W-2:0] f_ph_r;
  logic [U_W-1:0]     f_ux_r, f_uy_r;
  logic               f_negx_r, f_negy_r;
  logic [Q_W-1:0]     f_q1_r, f_q2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      f_pl_r   <= e_gain_r * e_smag_r[U_W-1:0];
      f_ph_r   <= e_gain_r * e_smag_r[SMAG_W-1:U_W];
      f_ux_r   <= e_ux_r;
      f_uy_r   <= e_uy_r;
      f_negx_r <= e_negx_r;
      f_negy_r <= e_negy_r;
      f_q1_r   <= e_q1_r;
      f_q2_r   <= e_q2_r;
    end
  end

  // stage g: force magnitude
  logic [FORCE_W+FRAC_W-1:0] g_sum;
  logic [FORCE_W-1:0]        g_force_r;
  logic [U_W-1:0]            g_ux_r, g_uy_r;
  logic                      g_negx_r, g_negy_r;
  logic [Q_W-1:0]            g_q1_r, g_q2_r;

  assign g_sum = {f_ph_r, {U_W{1'b0}}} + (FORCE_W+FRAC_W)'(f_pl_r);

  always_ff @(posedge clk) begin
    if (en) begin
      g_force_r <= g_sum[FORCE_W+FRAC_W-1:FRAC_W];
      g_ux_r    <= f_ux_r;
      g_uy_r    <= f_uy_r;
      g_negx_r  <= f_negx_r;
      g_negy_r  <= f_negy_r;
      g_q1_r    <= f_q1_r;
      g_q2_r    <= f_q2_r;
    end
  end

  // stage h: force along each axis, partial products
  logic [HALF_W+U_W-1:0] h_xh_r, h_xl_r, h_yh_r, h_yl_r;
  logic                  h_negx_r, h_negy_r;
  logic [Q_W-1:0]        h_q1_r, h_q2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      h_xh_r   <= g_force_r[FORCE_W-1:HALF_W] * g_ux_r;
      h_xl_r   <= g_force_r[HALF_W-1:0] * g_ux_r;
      h_yh_r   <= g_force_r[FORCE_W-1:HALF_W] * g_uy_r;
      h_yl_r   <= g_force_r[HALF_W-1:0] * g_uy_r;
      h_negx_r <= g_negx_r;
      h_negy_r <= g_negy_r;
      h_q1_r   <= g_q1_r;
      h_q2_r   <= g_q2_r;
    end
  end

  // stage i: recombine axis forces
  logic [HALF_W+U_W+HALF_W-1:0] x_sum, y_sum;
  logic [FORCE_W-1:0]           i_fx_r, i_fy_r;
  logic                         i_negx_r, i_negy_r;
  logic [Q_W-1:0]               i_q1_r, i_q2_r;

  assign x_sum = {h_xh_r, {HALF_W{1'b0}}} + (HALF_W+U_W+HALF_W)'(h_xl_r);
  assign y_sum = {h_yh_r, {HALF_W{1'b0}}} + (HALF_W+U_W+HALF_W)'(h_yl_r);

  always_ff @(posedge clk) begin
    if (en) begin
      i_fx_r   <= x_sum[FORCE_W+FRAC_W-1:FRAC_W];
      i_fy_r   <= y_sum[FORCE_W+FRAC_W-1:FRAC_W];
      i_negx_r <= h_negx_r;
      i_negy_r <= h_negy_r;
      i_q1_r   <= h_q1_r;
      i_q2_r   <= h_q2_r;
    end
  end

  // stages j and k: scale by dt/mass, the second body takes the opposite sign
  spv_scale_sat u_first_x (
    .clk (clk), .en (en), .f_i (i_fx_r), .q_i (i_q1_r), .neg_i (i_negx_r),
    .dv_o (out_item.first_dv_x)
  );
  spv_scale_sat u_first_y (
    .clk (clk), .en (en), .f_i (i_fy_r), .q_i (i_q1_r), .neg_i (i_negy_r),
    .dv_o (out_item.first_dv_y)
  );
  spv_scale_sat u_second_x (
    .clk (clk), .en (en), .f_i (i_fx_r), .q_i (i_q2_r), .neg_i (!i_negx_r),
    .dv_o (out_item.second_dv_x)
  );
  spv_scale_sat u_second_y (
    .clk (clk), .en (en), .f_i (i_fy_r), .q_i (i_q2_r), .neg_i (!i_negy_r),
    .dv_o (out_item.second_dv_y)
  );

endmodule

FILE: src/spv_root_step.sv
// ----------------------------------------------------------------------------
// spv_root_step
// one digit of a restoring square root, two radicand bits per step
// ----------------------------------------------------------------------------
module spv_root_step import spv_pkg::*; (
  input  logic [SREM_W-1:0] rem_i,
  input  logic [ROOT_W-1:0] root_i,
  input  logic [1:0]        pair_i,
  output logic [SREM_W-1:0] rem_o,
  output logic [ROOT_W-1:0] root_o
);

  logic [SREM_W+1:0] rem_sh;
  logic [SREM_W+1:0] trial;
  logic [SREM_W+1:0] diff;
  logic              ge;

  // bring in the next bit pair and try root*4+1
  assign rem_sh = {rem_i, pair_i};
  assign trial  = {2'b00, root_i, 2'b01};
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;
  assign rem_o  = ge ? diff[SREM_W-1:0] : rem_sh[SREM_W-1:0];
  assign root_o = {root_i[ROOT_W-2:0], ge};

endmodule

FILE: src/spv_div_step.sv
// ----------------------------------------------------------------------------
// spv_div_step
// one quotient bit of a restoring divider
// ----------------------------------------------------------------------------
module spv_div_step import spv_pkg::*; (
  input  logic [DREM_W-1:0] rem_i,
  input  logic              bit_i,
  input  logic [DREM_W-1:0] dvs_i,
  output logic [DREM_W-1:0] rem_o,
  output logic              q_o
);

  logic [DREM_W:0] rem_sh;
  logic [DREM_W:0] diff;

  // shift in one dividend bit and subtract where it fits
  assign rem_sh = {rem_i, bit_i};
  assign q_o    = rem_sh >= {1'b0, dvs_i};
  assign diff   = rem_sh - {1'b0, dvs_i};
  assign rem_o  = q_o ? diff[DREM_W-1:0] : rem_sh[DREM_W-1:0];

endmodule

FILE: src/spv_scale_sat.sv
// ----------------------------------------------------------------------------
// spv_scale_sat
// force times dt/mass in Q16.16, saturated and signed, two register stages
// ----------------------------------------------------------------------------
module spv_scale_sat import spv_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic [FORCE_W-1:0]      f_i,
  input  logic [Q_W-1:0]          q_i,
  input  logic                    neg_i,
  output logic signed [POS_W-1:0] dv_o
);

  logic [HALF_W-1:0]    f_hi;
  logic [Q_W-HALF_W-1:0] q_hi;
  logic                 sat;
  logic [FORCE_W-1:0]   op_a;
  logic [HALF_W-1:0]    op_b;
  logic                 j_sat_r;
  logic                 j_neg_r;
  logic [FORCE_W-1:0]   j_hi_r;
  logic [FORCE_W-1:0]   j_lo_r;
  logic [R_W+FRAC_W-1:0] sum;
  logic [R_W-1:0]       res;
  logic [R_W-1:0]       cap;
  logic [R_W-1:0]       mag;
  logic [POS_W-1:0]     dv_r;

  // both upper halves set means the product is far beyond the range;
  // otherwise one operand fits in a half word
  assign f_hi = f_i[FORCE_W-1:HALF_W];
  assign q_hi = q_i[Q_W-1:HALF_W];
  assign sat  = (f_hi != '0) && (q_hi != '0);
  assign op_a = (q_hi == '0) ? f_i : {1'b0, q_i};
  assign op_b = (q_hi == '0) ? q_i[HALF_W-1:0] : f_i[HALF_W-1:0];

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      j_sat_r <= sat;
      j_neg_r <= neg_i;
      j_hi_r  <= op_a[FORCE_W-1:HALF_W] * op_b;
      j_lo_r  <= op_a[HALF_W-1:0] * op_b;
    end
  end

  // recombine, drop the fraction, clip and apply the sign
  assign sum = {j_hi_r, {HALF_W{1'b0}}} + (R_W+FRAC_W)'(j_lo_r);
  assign res = sum[R_W+FRAC_W-1:FRAC_W];
  assign cap = j_neg_r ? CAP_NEG : CAP_POS;
  assign mag = (j_sat_r || (res > cap)) ? cap : res;

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r <= j_neg_r ? (POS_W'(0) - mag[POS_W-1:0]) : mag[POS_W-1:0];
    end
  end

  assign dv_o = dv_r;

endmodule

FILE: src/spv_checker.sv
// ----------------------------------------------------------------------------
// spv_checker
// port-level checks of the spring pair velocity delta block
// ----------------------------------------------------------------------------
`include "spring_pair_velocity_delta_defines.svh"

module spv_checker import spv_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [POS_W-1:0] first_dv_x,
  input logic signed [POS_W-1:0] first_dv_y,
  input logic signed [POS_W-1:0] second_dv_x,
  input logic signed [POS_W-1:0] second_dv_y
);

  // a held item stays
  `SPV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "item dropped while stalled")

  // a held item keeps its payload
  `SPV_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(first_dv_x) && $stable(first_dv_y) && $stable(second_dv_x) && $stable(second_dv_y), "payload changed while stalled")

  // an empty output never blocks the input
  `SPV_ASSERT_NOW(a_ready_free, clk, rst_n, !out_valid, in_ready, "input blocked with empty output")

  // the two bodies are pushed in opposite senses
  `SPV_ASSERT_NOW(a_sign_x, clk, rst_n, out_valid && first_dv_x[POS_W-1], !second_dv_x[POS_W-1], "x changes share a sign")

  `SPV_ASSERT_NOW(a_sign_y, clk, rst_n, out_valid && first_dv_y[POS_W-1], !second_dv_y[POS_W-1], "y changes share a sign")

endmodule

bind spring_pair_velocity_delta spv_checker u_spv_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_item.ready),
  .out_valid   (out_item.valid),
  .out_ready   (out_item.ready),
  .first_dv_x  (out_item.first_dv_x),
  .first_dv_y  (out_item.first_dv_y),
  .second_dv_x (out_item.second_dv_x),
  .second_dv_y (out_item.second_dv_y)
);
